// ===== src/usi_pkg.sv =====
// Shared types and constants for the deduplicating set insert block.
// Used by usi_cell, usi_chain and unique_set_insert_with_max_top.
`default_nettype none
package usi_pkg;

  localparam int CAPACITY = 128;
  localparam int DATA_W   = 32;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int OUT_CNT_W = 8;

  localparam logic [1:0] ST_ADDED = 2'd0;
  localparam logic [1:0] ST_DUP   = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic              tok;
    logic              hit;
    logic [DATA_W-1:0] key;
  } tok_t;

endpackage
`default_nettype wire

// ===== src/usi_cell.sv =====
// One storage cell of the set: holds one entry, compares the passing key
// and hands the token to its neighbour. Depends on usi_pkg.
`default_nettype none
module usi_cell (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic [usi_pkg::IDX_W-1:0] idx_i,
  input  wire logic [usi_pkg::CNT_W-1:0] count_i,
  input  wire usi_pkg::tok_t           tok_i,
  output usi_pkg::tok_t                tok_o
);

  logic [usi_pkg::DATA_W-1:0] entry_r;
  usi_pkg::tok_t              tok_r;
  usi_pkg::tok_t              tok_nxt;
  logic                       occupied;
  logic                       match;

  assign occupied = usi_pkg::CNT_W'(idx_i) < count_i;
  assign match    = occupied && (entry_r == tok_i.key);

  always_comb begin
    tok_nxt     = tok_i;
    tok_nxt.hit = tok_i.hit | (tok_i.tok & match);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.tok <= 1'b0;
    end else begin
      tok_r.tok <= tok_nxt.tok;
    end
    tok_r.hit <= tok_nxt.hit;
    tok_r.key <= tok_nxt.key;
  end

  always_ff @(posedge clk) begin
    if (tok_i.tok && !tok_i.hit && (usi_pkg::CNT_W'(idx_i) == count_i)) begin
      entry_r <= tok_i.key;
    end
  end

  assign tok_o = tok_r;

endmodule
`default_nettype wire

// ===== src/usi_chain.sv =====
// Row of CAPACITY cells; the token enters at the head and leaves at the tail.
// Depends on usi_pkg and usi_cell.
`default_nettype none
module usi_chain (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic [usi_pkg::CNT_W-1:0] count_i,
  input  wire usi_pkg::tok_t             head_i,
  output usi_pkg::tok_t                  tail_o
);

  usi_pkg::tok_t link [0:usi_pkg::CAPACITY];

  assign link[0] = head_i;

  for (genvar g = 0; g < usi_pkg::CAPACITY; g++) begin : g_cell
    usi_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .idx_i   (usi_pkg::IDX_W'(g)),
      .count_i (count_i),
      .tok_i   (link[g]),
      .tok_o   (link[g+1])
    );
  end

  assign tail_o = link[usi_pkg::CAPACITY];

endmodule
`default_nettype wire

// ===== src/unique_set_insert_with_max_top.sv =====
// Deduplicating set insert: top level with sequencer, count and running maximum.
// The result follows the token's walk through the cell row; a full set answers without a token.
// Throughput: one beat at a time, as busy holds off start while the token walks the cell row;
// a full set takes one beat per cycle.
// The receiver cannot stall; each result is shown for one cycle on out_strobe.
// Reset (rst_n, synchronous, active low) empties the set and clears the maximum.
// Depends on usi_pkg and usi_chain.
`default_nettype none
module unique_set_insert_with_max_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [31:0] in_value,
  output logic             out_strobe,
  output logic [1:0]       out_status,
  output logic [7:0]       out_count,
  output logic [31:0]      out_largest
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } state_t;

  state_t                      state_r, state_nxt;
  logic [usi_pkg::CNT_W-1:0]   count_r, count_nxt;
  logic [usi_pkg::DATA_W-1:0]  max_r, max_nxt;
  logic                        strobe_r, strobe_nxt;
  logic [1:0]                  status_r, status_nxt;
  logic [usi_pkg::CNT_W-1:0]   ocount_r, ocount_nxt;
  logic [usi_pkg::DATA_W-1:0]  largest_r, largest_nxt;
  logic                        accept;
  logic                        full;
  usi_pkg::tok_t               head;
  usi_pkg::tok_t               tail;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;
  assign full   = (count_r == usi_pkg::CNT_W'(usi_pkg::CAPACITY));

  always_comb begin
    head.tok = accept && !full;
    head.hit = 1'b0;
    head.key = in_value;
  end

  usi_chain u_chain (
    .clk     (clk),
    .rst_n   (rst_n),
    .count_i (count_r),
    .head_i  (head),
    .tail_o  (tail)
  );

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    max_nxt     = max_r;
    strobe_nxt  = 1'b0;
    status_nxt  = status_r;
    ocount_nxt  = ocount_r;
    largest_nxt = largest_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (full) begin
            strobe_nxt  = 1'b1;
            status_nxt  = usi_pkg::ST_FULL;
            ocount_nxt  = count_r;
            largest_nxt = max_r;
          end else begin
            state_nxt = S_RUN;
          end
        end
      end
      S_RUN: begin
        if (tail.tok) begin
          state_nxt  = S_IDLE;
          strobe_nxt = 1'b1;
          if (tail.hit) begin
            status_nxt = usi_pkg::ST_DUP;
          end else begin
            status_nxt = usi_pkg::ST_ADDED;
            count_nxt  = count_r + 1'b1;
            if ((count_r == '0) || ($signed(tail.key) > $signed(max_r))) begin
              max_nxt = tail.key;
            end
          end
          ocount_nxt  = count_nxt;
          largest_nxt = (count_nxt == '0) ? '0 : max_nxt;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      max_r    <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      max_r    <= max_nxt;
      strobe_r <= strobe_nxt;
    end
    status_r  <= status_nxt;
    ocount_r  <= ocount_nxt;
    largest_r <= largest_nxt;
  end

  assign out_strobe  = strobe_r;
  assign out_status  = status_r;
  assign out_count   = usi_pkg::OUT_CNT_W'(ocount_r);
  assign out_largest = largest_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= usi_pkg::CNT_W'(usi_pkg::CAPACITY))
    else $error("entry count beyond capacity");

  a_tail_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    tail.tok |-> (state_r == S_RUN))
    else $error("token left the chain outside a run");

  a_full_no_token: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && full) |=> (out_strobe && (out_status == usi_pkg::ST_FULL) && !busy))
    else $error("full set not answered at once");

  a_add_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN && tail.tok && !tail.hit) |=> (count_r == $past(count_r) + 1'b1))
    else $error("add did not grow the count");

endmodule
`default_nettype wire
